>>> design/scba_pkg.sv
`default_nettype none

package scba_pkg;

    localparam int SIZE_W   = 8;
    localparam int HANDLE_W = 10;
    localparam int STATUS_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 3'd0,
        STATUS_EMPTY    = 3'd1,
        STATUS_FULL     = 3'd2,
        STATUS_TOOBIG   = 3'd3,
        STATUS_NOTREADY = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_ACCESS,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic lookup;
        logic access;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

>>> design/scba_ram.sv
`default_nettype none

module scba_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/scba_ctrl.sv
`default_nettype none

module scba_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output scba_pkg::ctrl_cmd_t       cmd,
    input  wire scba_pkg::dp_sts_t    sts
);

    import scba_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_ACCESS;
            end
            ST_ACCESS:
            begin
                cmd.access = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/scba_dp.sv
`default_nettype none

module scba_dp #(
    parameter int NUM_SIZES      = 64,
    parameter int SLOTS_PER_SIZE = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire scba_pkg::ctrl_cmd_t             cmd,
    output scba_pkg::dp_sts_t                    sts,
    input  wire logic                            in_func,
    input  wire logic [scba_pkg::SIZE_W-1:0]     in_size,
    input  wire logic [scba_pkg::HANDLE_W-1:0]   in_handle,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [scba_pkg::STATUS_W-1:0]        out_status,
    output logic [scba_pkg::HANDLE_W-1:0]        out_handle
);

    import scba_pkg::*;

    localparam int DEPTH  = NUM_SIZES * SLOTS_PER_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CLS_W  = $clog2(NUM_SIZES);
    localparam int SLOT_W = $clog2(SLOTS_PER_SIZE);
    localparam int CNT_W  = $clog2(SLOTS_PER_SIZE + 1);
    localparam int CW     = SLOT_W + CNT_W;

    logic                func_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [HANDLE_W-1:0] hin_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic [ADDR_W-1:0]   pop_addr_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic [NUM_SIZES-1:0] class_ready_reg;
    status_t             status_reg;
    logic                pop_reg;
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [HANDLE_W-1:0] m_handle_reg;

    logic [CLS_W-1:0]    cls_idx;
    logic                too_big;
    logic [CW-1:0]       cls_rdata;
    logic [SLOT_W-1:0]   cls_top;
    logic [CNT_W-1:0]    cls_cnt;
    logic [SLOT_W-1:0]   top_next;
    logic [CNT_W-1:0]    cnt_next;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   slot_addr;
    logic                pop;
    logic                push;
    status_t             status_next;

    logic                cls_we;
    logic [CLS_W-1:0]    cls_addr;
    logic [CW-1:0]       cls_wdata;
    logic                hnd_we;
    logic [ADDR_W-1:0]   hnd_addr;
    logic [HANDLE_W-1:0] hnd_wdata;
    logic [HANDLE_W-1:0] hnd_rdata;

    assign cls_idx = size_reg[CLS_W-1:0];
    assign too_big = {1'b0, size_reg} >= (SIZE_W + 1)'(NUM_SIZES);
    assign cls_top = cls_rdata[CW-1:CNT_W];
    assign cls_cnt = cls_rdata[CNT_W-1:0];

    always_comb
    begin
        status_next = STATUS_OK;
        pop         = 1'b0;
        push        = 1'b0;
        top_next    = cls_top;
        cnt_next    = cls_cnt;
        slot        = cls_top;
        if (too_big)
        begin
            status_next = STATUS_TOOBIG;
        end
        else if (!func_reg)
        begin
            if (cls_cnt == '0)
            begin
                status_next = STATUS_EMPTY;
            end
            else
            begin
                pop      = 1'b1;
                top_next = (cls_top == SLOT_W'(SLOTS_PER_SIZE - 1)) ? '0
                                                                    : cls_top + SLOT_W'(1);
                cnt_next = cls_cnt - CNT_W'(1);
            end
        end
        else if (!class_ready_reg[cls_idx])
        begin
            status_next = STATUS_NOTREADY;
        end
        else if (cls_cnt == CNT_W'(SLOTS_PER_SIZE))
        begin
            status_next = STATUS_FULL;
        end
        else
        begin
            push     = 1'b1;
            top_next = (cls_top == '0) ? SLOT_W'(SLOTS_PER_SIZE - 1) : cls_top - SLOT_W'(1);
            cnt_next = cls_cnt + CNT_W'(1);
            slot     = top_next;
        end
    end

    // The clearing pass writes every handle entry and, over its first classes, the class words.
    assign cls_we    = (cmd.clear && (clr_cnt_reg < ADDR_W'(NUM_SIZES)))
                       || (cmd.access && (pop || push));
    assign cls_addr  = cmd.clear ? clr_cnt_reg[CLS_W-1:0] : cls_idx;
    assign cls_wdata = cmd.clear ? {SLOT_W'(0), CNT_W'(SLOTS_PER_SIZE)} : {top_next, cnt_next};

    // The handle address is held after the access so that a stalled result keeps its handle.
    assign slot_addr = base_reg + ADDR_W'(slot);
    assign hnd_we    = cmd.clear || (cmd.access && push);
    assign hnd_addr  = cmd.clear ? clr_cnt_reg : (cmd.access ? slot_addr : pop_addr_reg);
    assign hnd_wdata = cmd.clear ? HANDLE_W'(clr_cnt_reg) : hin_reg;

    scba_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_SIZES)
    ) u_cls_ram (
        .clk   (clk),
        .we    (cls_we),
        .addr  (cls_addr),
        .wdata (cls_wdata),
        .rdata (cls_rdata)
    );

    scba_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (DEPTH)
    ) u_hnd_ram (
        .clk   (clk),
        .we    (hnd_we),
        .addr  (hnd_addr),
        .wdata (hnd_wdata),
        .rdata (hnd_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg     <= '0;
            class_ready_reg <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cmd.access && !too_big && !func_reg)
            begin
                class_ready_reg[cls_idx] <= 1'b1;
            end
            if (cmd.load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= in_func;
            size_reg <= in_size;
            hin_reg  <= in_handle;
        end
        if (cmd.lookup)
        begin
            base_reg <= ADDR_W'(cls_idx) * ADDR_W'(SLOTS_PER_SIZE);
        end
        if (cmd.access)
        begin
            status_reg   <= status_next;
            pop_reg      <= pop;
            pop_addr_reg <= slot_addr;
        end
        if (cmd.load_out)
        begin
            m_status_reg <= status_reg;
            m_handle_reg <= pop_reg ? hnd_rdata : '0;
        end
    end

    assign sts.clear_last = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
    assign sts.out_free   = !m_valid_reg || out_ready;

    assign out_valid  = m_valid_reg;
    assign out_status = m_status_reg;
    assign out_handle = m_handle_reg;

endmodule

`default_nettype wire

>>> design/size_class_block_allocator_core.sv
// Size-class block allocator with one stack of free block handles per size class.
// Requests arrive on the slave stream: tuser carries the function (allocate or free),
// tdata carries the size class and, for a free, the handle being returned. Each item
// gives exactly one result item on the master stream: a status code and, on a
// successful allocate, the handle taken from the class.
// An item passes through these steps in order: it is accepted and captured, the class word
// is read, the class is updated and the handle memory accessed, and the popped handle is
// collected and the result loaded into the output register. The result is offered on the
// master stream once loaded, and the block takes no new item until the last has loaded its
// result; the single-ported class and handle memories are walked in sequence per item.
// After reset the block runs a clearing pass that fills the handle memory with its initial
// handles and resets every class word; tready stays low until it ends.
// The result sits in an output register. A new item is accepted while a result waits;
// if the receiver stalls, that next item waits in its last step until the register frees.
`default_nettype none

module size_class_block_allocator_core #(
    parameter int NUM_SIZES      = 64,
    parameter int SLOTS_PER_SIZE = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // size [7:0], handle [17:8], zero fill
    input  wire logic [0:0]  s_tuser,   // func [0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // status [2:0], handle_out [12:3], zero fill
);

    import scba_pkg::*;

    ctrl_cmd_t           cmd;
    dp_sts_t             sts;
    logic [STATUS_W-1:0] out_status;
    logic [HANDLE_W-1:0] out_handle;

    scba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    scba_dp #(
        .NUM_SIZES      (NUM_SIZES),
        .SLOTS_PER_SIZE (SLOTS_PER_SIZE)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_func    (s_tuser[0]),
        .in_size    (s_tdata[SIZE_W-1:0]),
        .in_handle  (s_tdata[SIZE_W+HANDLE_W-1:SIZE_W]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_handle (out_handle)
    );

    assign m_tdata = {3'b000, out_handle, out_status};

endmodule

`default_nettype wire

>>> test/size_class_block_allocator_core_tb.sv
module size_class_block_allocator_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import scba_pkg::*;

    localparam int NUM_SIZES      = 64;
    localparam int SLOTS_PER_SIZE = 16;
    localparam int ITEMS_PER_PHASE = 660;
    localparam int HOLD_CYCLES    = 300;
    localparam int STALL_LIMIT    = 5000;
    localparam int DRAIN_CYCLES   = 16;

    typedef enum logic {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } func_t;

    class alloc_scoreboard;
        logic [HANDLE_W-1:0] slot_handle [NUM_SIZES][SLOTS_PER_SIZE];
        int unsigned         top_pos [NUM_SIZES];
        int unsigned         free_left [NUM_SIZES];
        bit                  set_up [NUM_SIZES];
        status_t             status_due [$];
        logic [HANDLE_W-1:0] handle_due [$];
        int                  errors;

        function new();
            errors = 0;
            for (int c = 0; c < NUM_SIZES; c++)
            begin
                for (int s = 0; s < SLOTS_PER_SIZE; s++)
                    slot_handle[c][s] = HANDLE_W'(c * SLOTS_PER_SIZE + s);
                top_pos[c]   = 0;
                free_left[c] = SLOTS_PER_SIZE;
                set_up[c]    = 1'b0;
            end
        endfunction

        function void note_request(func_t fn, logic [SIZE_W-1:0] sz,
                                   logic [HANDLE_W-1:0] h);
            status_t             st;
            logic [HANDLE_W-1:0] ho;
            st = STATUS_OK;
            ho = '0;
            if (sz >= NUM_SIZES)
                st = STATUS_TOOBIG;
            else if (fn == FN_ALLOC)
            begin
                set_up[sz] = 1'b1;
                if (free_left[sz] == 0)
                    st = STATUS_EMPTY;
                else
                begin
                    ho = slot_handle[sz][top_pos[sz]];
                    free_left[sz]--;
                    top_pos[sz] = (top_pos[sz] + 1) % SLOTS_PER_SIZE;
                end
            end
            else if (!set_up[sz])
                st = STATUS_NOTREADY;
            else if (free_left[sz] >= SLOTS_PER_SIZE)
                st = STATUS_FULL;
            else
            begin
                top_pos[sz] = (top_pos[sz] == 0) ? SLOTS_PER_SIZE - 1 : top_pos[sz] - 1;
                slot_handle[sz][top_pos[sz]] = h;
                free_left[sz]++;
            end
            status_due.push_back(st);
            handle_due.push_back(ho);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [HANDLE_W-1:0] ho);
            status_t             st_exp;
            logic [HANDLE_W-1:0] ho_exp;
            if (status_due.size() == 0)
            begin
                $display("%0t: unexpected result item, status %0d handle %0d", $time, st, ho);
                errors++;
                return;
            end
            st_exp = status_due.pop_front();
            ho_exp = handle_due.pop_front();
            if (st !== st_exp)
            begin
                $display("%0t: status expected %0d, actual %0d", $time, st_exp, st);
                errors++;
            end
            if (ho !== ho_exp)
            begin
                $display("%0t: handle_out expected %0d, actual %0d", $time, ho_exp, ho);
                errors++;
            end
        endfunction

        function int pending();
            return status_due.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    alloc_scoreboard sb;
    int unsigned     send_idle_pct = 0;
    int unsigned     recv_idle_pct = 0;
    logic            pressure_go = 1'b0;
    logic            pressure_seen = 1'b0;
    int unsigned     hold_left = 0;
    int unsigned     quiet_cycles = 0;

    size_class_block_allocator_core #(
        .NUM_SIZES      (NUM_SIZES),
        .SLOTS_PER_SIZE (SLOTS_PER_SIZE)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready      <= 1'b0;
            hold_left     <= 0;
            pressure_seen <= 1'b0;
        end
        else if (pressure_go != pressure_seen)
        begin
            pressure_seen <= pressure_go;
            hold_left     <= HOLD_CYCLES;
            m_tready      <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[2:0], m_tdata[12:3]);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("size_class_block_allocator_core_tb: done, errors");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input func_t fn, input logic [SIZE_W-1:0] sz,
                                input logic [HANDLE_W-1:0] h);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, h, sz};
        s_tuser  <= fn;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(fn, sz, h);
    endtask

    initial
    begin
        int unsigned       roll;
        logic [SIZE_W-1:0] sz;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 36;
                    recv_idle_pct <= 84;
                end
                1:
                begin
                    send_idle_pct = 84;
                    recv_idle_pct <= 36;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                    pressure_go <= ~pressure_go;
                end
            endcase

            if (phase == 0)
            begin
                // Oversized classes, a free before any allocate, a free into a full
                // class, reuse of a freed handle and draining a class until empty.
                send_request(FN_ALLOC, 8'd255, 10'd1023);
                send_request(FN_FREE, 8'(NUM_SIZES), 10'd0);
                send_request(FN_FREE, 8'(NUM_SIZES - 1), 10'd1023);
                send_request(FN_ALLOC, 8'd0, 10'd1023);
                send_request(FN_FREE, 8'd0, 10'd1023);
                send_request(FN_FREE, 8'd0, 10'd0);
                send_request(FN_ALLOC, 8'd0, 10'd0);
                repeat (SLOTS_PER_SIZE + 1)
                    send_request(FN_ALLOC, 8'(NUM_SIZES - 1), 10'($urandom_range(1023)));
                send_request(FN_FREE, 8'(NUM_SIZES - 1), 10'd512);
            end

            // Most traffic goes to a few classes so that they run empty and full often.
            repeat (ITEMS_PER_PHASE)
            begin
                roll = $urandom_range(99);
                if (roll < 70)
                begin
                    case ($urandom_range(3))
                        0: sz = 8'd0;
                        1: sz = 8'd1;
                        2: sz = 8'(NUM_SIZES - 2);
                        default: sz = 8'(NUM_SIZES - 1);
                    endcase
                end
                else if (roll < 90)
                    sz = 8'($urandom_range(NUM_SIZES - 1));
                else
                    sz = 8'($urandom_range(255, NUM_SIZES));
                send_request(func_t'($urandom_range(1)), sz, 10'($urandom_range(1023)));
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() > 0)
        begin
            $display("%0t: %0d result items never arrived", $time, sb.pending());
            sb.errors++;
        end

        if (sb.errors == 0)
            $display("size_class_block_allocator_core_tb: done, clean");
        else
            $display("size_class_block_allocator_core_tb: done, errors");
        $finish;
    end

endmodule
